// ===== hdl/uqsd_pkg.sv =====
// Shared types, character codes and helpers for the URL query string decoder.
package uqsd_pkg;

   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_QUERY   = 8'h3F;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

   typedef enum logic [2:0] {
      MODE_PATH  = 3'd0,
      MODE_KEY   = 3'd1,
      MODE_VALUE = 3'd2,
      MODE_ESC1  = 3'd3,
      MODE_ESC2  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      FIELD_PATH  = 2'd0,
      FIELD_KEY   = 2'd1,
      FIELD_VALUE = 2'd2
   } field_type;

   typedef struct packed {
      mode_type  mode;
      field_type ret;
      logic [3:0] high_nibble;
   } state_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      field_type  field_tag;
      logic       field_closed;
      logic       empty_value;
      logic       string_end;
   } rsp_type;

   localparam state_type STATE_RESET = '{mode: MODE_PATH, ret: FIELD_PATH, high_nibble: 4'd0};

   // Non-hex characters decode to zero.
   function automatic logic [3:0] hex_value(input logic [7:0] ch);
      logic [7:0] v;
      v = 8'd0;
      if (ch >= 8'h41 && ch <= 8'h46) begin
         v = ch - 8'h41 + HEX_LETTER_BASE;
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         v = ch - 8'h61 + HEX_LETTER_BASE;
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         v = ch - 8'h30;
      end
      return v[3:0];
   endfunction

   function automatic field_type field_of(input mode_type m);
      field_type f;
      unique case (m)
         MODE_KEY:   f = FIELD_KEY;
         MODE_VALUE: f = FIELD_VALUE;
         default:    f = FIELD_PATH;
      endcase
      return f;
   endfunction

   function automatic mode_type mode_of(input field_type f);
      mode_type m;
      unique case (f)
         FIELD_KEY:   m = MODE_KEY;
         FIELD_VALUE: m = MODE_VALUE;
         default:     m = MODE_PATH;
      endcase
      return m;
   endfunction

endpackage

// ===== hdl/uqsd_step.sv =====
// Per-character parse step: next parser state and the result for one transaction.
module uqsd_step (
   input  uqsd_pkg::state_type state,
   input  logic                kind,
   input  logic [7:0]          char_in,
   output uqsd_pkg::state_type state_next,
   output logic                emit,
   output uqsd_pkg::rsp_type   rsp
);

   logic                escaped;
   uqsd_pkg::field_type cur_field;
   uqsd_pkg::field_type ret_field;
   uqsd_pkg::field_type tag;

   assign escaped   = (state.mode == uqsd_pkg::MODE_ESC1) || (state.mode == uqsd_pkg::MODE_ESC2);
   assign cur_field = uqsd_pkg::field_of(state.mode);
   assign ret_field = uqsd_pkg::field_of(uqsd_pkg::mode_of(state.ret));
   assign tag       = escaped ? ret_field : cur_field;

   // Next state.
   always_comb begin
      state_next = state;
      priority if (kind) begin
         state_next = uqsd_pkg::STATE_RESET;
      end else if (char_in == uqsd_pkg::CHAR_PLUS) begin
         state_next = state;
      end else if (char_in == uqsd_pkg::CHAR_PERCENT && escaped) begin
         state_next.mode = uqsd_pkg::MODE_ESC1;
      end else if (state.mode == uqsd_pkg::MODE_ESC1) begin
         state_next.high_nibble = uqsd_pkg::hex_value(char_in);
         state_next.mode        = uqsd_pkg::MODE_ESC2;
      end else if (state.mode == uqsd_pkg::MODE_ESC2) begin
         state_next.mode = uqsd_pkg::mode_of(ret_field);
      end else if (char_in == uqsd_pkg::CHAR_PERCENT && cur_field != uqsd_pkg::FIELD_PATH) begin
         state_next.ret  = cur_field;
         state_next.mode = uqsd_pkg::MODE_ESC1;
      end else if (cur_field == uqsd_pkg::FIELD_PATH) begin
         state_next.mode = (char_in == uqsd_pkg::CHAR_QUERY) ? uqsd_pkg::MODE_KEY
                                                              : uqsd_pkg::MODE_PATH;
      end else if (cur_field == uqsd_pkg::FIELD_KEY) begin
         state_next.mode = (char_in == uqsd_pkg::CHAR_EQUAL) ? uqsd_pkg::MODE_VALUE
                                                              : uqsd_pkg::MODE_KEY;
      end else begin
         state_next.mode = (char_in == uqsd_pkg::CHAR_AMP) ? uqsd_pkg::MODE_KEY
                                                            : uqsd_pkg::MODE_VALUE;
      end
   end

   // Result.
   always_comb begin
      emit             = 1'b1;
      rsp.byte_valid   = 1'b0;
      rsp.out_byte     = 8'd0;
      rsp.field_tag    = cur_field;
      rsp.field_closed = 1'b0;
      rsp.empty_value  = 1'b0;
      rsp.string_end   = 1'b0;
      priority if (kind) begin
         rsp.field_tag    = tag;
         rsp.field_closed = 1'b1;
         rsp.empty_value  = (tag == uqsd_pkg::FIELD_KEY);
         rsp.string_end   = 1'b1;
      end else if (char_in == uqsd_pkg::CHAR_PLUS) begin
         rsp.byte_valid = 1'b1;
         rsp.out_byte   = uqsd_pkg::CHAR_SPACE;
         rsp.field_tag  = tag;
      end else if (char_in == uqsd_pkg::CHAR_PERCENT && escaped) begin
         emit = 1'b0;
      end else if (state.mode == uqsd_pkg::MODE_ESC1) begin
         emit = 1'b0;
      end else if (state.mode == uqsd_pkg::MODE_ESC2) begin
         rsp.byte_valid = 1'b1;
         rsp.out_byte   = {state.high_nibble, uqsd_pkg::hex_value(char_in)};
         rsp.field_tag  = ret_field;
      end else if (char_in == uqsd_pkg::CHAR_PERCENT && cur_field != uqsd_pkg::FIELD_PATH) begin
         emit = 1'b0;
      end else if (cur_field == uqsd_pkg::FIELD_PATH && char_in == uqsd_pkg::CHAR_QUERY) begin
         rsp.field_closed = 1'b1;
      end else if (cur_field == uqsd_pkg::FIELD_KEY && char_in == uqsd_pkg::CHAR_AMP) begin
         rsp.field_closed = 1'b1;
         rsp.empty_value  = 1'b1;
      end else if (cur_field == uqsd_pkg::FIELD_KEY && char_in == uqsd_pkg::CHAR_EQUAL) begin
         rsp.field_closed = 1'b1;
      end else if (cur_field == uqsd_pkg::FIELD_VALUE && char_in == uqsd_pkg::CHAR_AMP) begin
         rsp.field_closed = 1'b1;
      end else begin
         rsp.byte_valid = 1'b1;
         rsp.out_byte   = char_in;
      end
   end

endmodule

// ===== hdl/url_query_string_decoder.sv =====
// URL query string decoder: splits a byte stream into tagged path, key and value bytes.
// A result is registered after its item leaves the input register, which also updates the parse state.
// Throughput: one transaction per cycle unless rsp_stall holds a result.
// Escape starts and first escape digits give no result.
// Reset (synchronous): empties both registers, parser returns to path mode.
module url_query_string_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_byte_valid,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_field_tag,
   output logic       rsp_field_closed,
   output logic       rsp_empty_value,
   output logic       rsp_string_end
);

   logic                in_valid_ff;
   logic                in_kind_ff;
   logic [7:0]          in_char_ff;
   uqsd_pkg::state_type state_ff;
   uqsd_pkg::state_type state_in;
   logic                out_valid_ff;
   uqsd_pkg::rsp_type   out_ff;
   uqsd_pkg::rsp_type   step_rsp;
   logic                step_emit;
   logic                out_ready;
   logic                advance;

   uqsd_step u_step (
      .state      (state_ff),
      .kind       (in_kind_ff),
      .char_in    (in_char_ff),
      .state_next (state_in),
      .emit       (step_emit),
      .rsp        (step_rsp)
   );

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= uqsd_pkg::STATE_RESET;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_ready) begin
            out_valid_ff <= advance && step_emit;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_kind_ff <= req_kind;
         in_char_ff <= req_char_in;
      end
      if (advance && step_emit) begin
         out_ff <= step_rsp;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_byte_valid   = out_ff.byte_valid;
   assign rsp_out_byte     = out_ff.out_byte;
   assign rsp_field_tag    = out_ff.field_tag;
   assign rsp_field_closed = out_ff.field_closed;
   assign rsp_empty_value  = out_ff.empty_value;
   assign rsp_string_end   = out_ff.string_end;

endmodule

// ===== hdl/uqsd_checker.sv =====
// Port-level checks for the URL query string decoder, bound to the top level.
module uqsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_byte_valid,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_field_tag,
   input logic       rsp_field_closed,
   input logic       rsp_empty_value,
   input logic       rsp_string_end
);

   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_field_closed && !rsp_byte_valid)
      else $error("end marker result does not close a field");

   a_byte_or_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_byte_valid && rsp_field_closed))
      else $error("result carries a byte and a closure");

   a_empty_on_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_value |-> rsp_field_closed
         && rsp_field_tag == uqsd_pkg::FIELD_KEY)
      else $error("empty value flagged outside a closed key");

   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_out_byte == 8'd0)
      else $error("nonzero byte on a closure result");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_field_tag) && $stable(rsp_field_closed))
      else $error("stalled result changed");

endmodule

bind url_query_string_decoder uqsd_checker u_uqsd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_byte_valid   (rsp_byte_valid),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_field_tag    (rsp_field_tag),
   .rsp_field_closed (rsp_field_closed),
   .rsp_empty_value  (rsp_empty_value),
   .rsp_string_end   (rsp_string_end)
);

// ===== bench/tb.sv =====
// Self-checking testbench for the URL query string decoder.
`timescale 1ns / 1ps

module tb;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;
   localparam int RESET_CYCLES  = 9;
   localparam int HOLD_CYCLES   = 60;
   localparam int SETTLE_CYCLES = 6;
   localparam int IDLE_PERCENT  = 11;
   localparam int RANDOM_ITEMS  = 800;
   localparam int LIMIT_CYCLES  = 200000;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_kind;
   logic [7:0] req_char_in;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_byte_valid;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_field_tag;
   logic       rsp_field_closed;
   logic       rsp_empty_value;
   logic       rsp_string_end;

   // parser state as the predictor sees it
   uqsd_pkg::mode_type   url_mode;
   uqsd_pkg::field_type  url_resume;
   logic [3:0]           url_high;

   uqsd_pkg::rsp_type    decoded_results[$];
   uqsd_pkg::rsp_type    oldest_result;
   int         mismatch_count = 0;
   int         items_sent = 0;
   int unsigned cycle_count = 0;
   logic       idle_on = 1'b1;
   logic       hold_req = 1'b0;
   logic       hold_ack = 1'b0;
   int         hold_left = 0;

   url_query_string_decoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_char_in      (req_char_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_field_tag    (rsp_field_tag),
      .rsp_field_closed (rsp_field_closed),
      .rsp_empty_value  (rsp_empty_value),
      .rsp_string_end   (rsp_string_end)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count == LIMIT_CYCLES);
      $display("tb NOT OK");
      $finish;
   end

   function automatic logic [3:0] digit_weight(input logic [7:0] ch);
      logic [7:0] folded;
      logic [7:0] w;
      folded = ch | 8'h20;
      w = 8'd0;
      if (ch >= "0" && ch <= "9") begin
         w = ch - "0";
      end else if (folded >= "a" && folded <= "f") begin
         w = folded - "a" + uqsd_pkg::HEX_LETTER_BASE;
      end
      return w[3:0];
   endfunction

   task automatic reset_url_state();
      url_mode   = uqsd_pkg::MODE_PATH;
      url_resume = uqsd_pkg::FIELD_PATH;
      url_high   = 4'd0;
   endtask

   // Advance the predicted parser by one accepted transaction.
   task automatic decode_step(input logic kind, input logic [7:0] ch);
      uqsd_pkg::rsp_type   r;
      logic                in_escape;
      logic                emits;
      uqsd_pkg::field_type open_field;
      r = '0;
      emits = 1'b1;
      in_escape = (url_mode == uqsd_pkg::MODE_ESC1 || url_mode == uqsd_pkg::MODE_ESC2);
      if (in_escape) begin
         open_field = url_resume;
      end else if (url_mode == uqsd_pkg::MODE_KEY) begin
         open_field = uqsd_pkg::FIELD_KEY;
      end else if (url_mode == uqsd_pkg::MODE_VALUE) begin
         open_field = uqsd_pkg::FIELD_VALUE;
      end else begin
         open_field = uqsd_pkg::FIELD_PATH;
      end

      if (kind == KIND_END) begin
         r.field_tag    = open_field;
         r.field_closed = 1'b1;
         r.empty_value  = (open_field == uqsd_pkg::FIELD_KEY);
         r.string_end   = 1'b1;
         reset_url_state();
      end else if (ch == uqsd_pkg::CHAR_PLUS) begin
         r.byte_valid = 1'b1;
         r.out_byte   = uqsd_pkg::CHAR_SPACE;
         r.field_tag  = open_field;
      end else if (in_escape && ch == uqsd_pkg::CHAR_PERCENT) begin
         url_mode = uqsd_pkg::MODE_ESC1;
         emits = 1'b0;
      end else if (url_mode == uqsd_pkg::MODE_ESC1) begin
         url_high = digit_weight(ch);
         url_mode = uqsd_pkg::MODE_ESC2;
         emits = 1'b0;
      end else if (url_mode == uqsd_pkg::MODE_ESC2) begin
         r.byte_valid = 1'b1;
         r.out_byte   = {url_high, digit_weight(ch)};
         r.field_tag  = url_resume;
         case (url_resume)
            uqsd_pkg::FIELD_KEY:   url_mode = uqsd_pkg::MODE_KEY;
            uqsd_pkg::FIELD_VALUE: url_mode = uqsd_pkg::MODE_VALUE;
            default:               url_mode = uqsd_pkg::MODE_PATH;
         endcase
      end else if (ch == uqsd_pkg::CHAR_PERCENT && open_field != uqsd_pkg::FIELD_PATH) begin
         url_resume = open_field;
         url_mode = uqsd_pkg::MODE_ESC1;
         emits = 1'b0;
      end else begin
         r.field_tag = open_field;
         case (open_field)
            uqsd_pkg::FIELD_PATH: begin
               url_mode = uqsd_pkg::MODE_PATH;
               if (ch == uqsd_pkg::CHAR_QUERY) begin
                  r.field_closed = 1'b1;
                  url_mode = uqsd_pkg::MODE_KEY;
               end else begin
                  r.byte_valid = 1'b1;
                  r.out_byte = ch;
               end
            end
            uqsd_pkg::FIELD_KEY: begin
               url_mode = uqsd_pkg::MODE_KEY;
               if (ch == uqsd_pkg::CHAR_AMP) begin
                  r.field_closed = 1'b1;
                  r.empty_value  = 1'b1;
               end else if (ch == uqsd_pkg::CHAR_EQUAL) begin
                  r.field_closed = 1'b1;
                  url_mode = uqsd_pkg::MODE_VALUE;
               end else begin
                  r.byte_valid = 1'b1;
                  r.out_byte = ch;
               end
            end
            default: begin
               url_mode = uqsd_pkg::MODE_VALUE;
               if (ch == uqsd_pkg::CHAR_AMP) begin
                  r.field_closed = 1'b1;
                  url_mode = uqsd_pkg::MODE_KEY;
               end else begin
                  r.byte_valid = 1'b1;
                  r.out_byte = ch;
               end
            end
         endcase
      end
      if (emits) begin
         decoded_results = {decoded_results, r};
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_results.size() == 0) begin
            report_mismatch("unexpected result", int'(rsp_out_byte), 0);
         end else begin
            oldest_result = decoded_results.pop_front();
            if (rsp_byte_valid !== oldest_result.byte_valid)
               report_mismatch("byte_valid", int'(rsp_byte_valid),
                               int'(oldest_result.byte_valid));
            if (rsp_out_byte !== oldest_result.out_byte)
               report_mismatch("out_byte", int'(rsp_out_byte), int'(oldest_result.out_byte));
            if (rsp_field_tag !== oldest_result.field_tag)
               report_mismatch("field_tag", int'(rsp_field_tag), int'(oldest_result.field_tag));
            if (rsp_field_closed !== oldest_result.field_closed)
               report_mismatch("field_closed", int'(rsp_field_closed),
                               int'(oldest_result.field_closed));
            if (rsp_empty_value !== oldest_result.empty_value)
               report_mismatch("empty_value", int'(rsp_empty_value),
                               int'(oldest_result.empty_value));
            if (rsp_string_end !== oldest_result.string_end)
               report_mismatch("string_end", int'(rsp_string_end),
                               int'(oldest_result.string_end));
         end
      end
   end

   // Result side: random stalls, or a long hold-off on request.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_ack  <= hold_req;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   // Offer one transaction and hold it until accepted.
   task automatic send_item(input logic kind, input logic [7:0] ch);
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_char_in <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_step(kind, ch);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         send_item(KIND_CHAR, s[i]);
      end
   endtask

   task automatic send_end();
      send_item(KIND_END, 8'($urandom_range(255)));
   endtask

   // Stop offering and wait until every predicted result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (decoded_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_text_byte();
      logic [7:0] b;
      case ($urandom_range(19))
         0:       b = uqsd_pkg::CHAR_PLUS;
         1, 2:    b = 8'($urandom_range(255));
         3, 4:    b = "0" + 8'($urandom_range(9));
         default: b = "a" + 8'($urandom_range(25));
      endcase
      return b;
   endfunction

   function automatic logic [7:0] pick_hex_char();
      logic [7:0] b;
      case ($urandom_range(7))
         0:       b = 8'($urandom_range(255));
         1, 2:    b = "A" + 8'($urandom_range(5));
         3, 4:    b = "a" + 8'($urandom_range(5));
         default: b = "0" + 8'($urandom_range(9));
      endcase
      return b;
   endfunction

   // Escape with occasional restart or embedded plus.
   task automatic send_escape();
      send_item(KIND_CHAR, uqsd_pkg::CHAR_PERCENT);
      if ($urandom_range(19) == 0) send_item(KIND_CHAR, uqsd_pkg::CHAR_PERCENT);
      if ($urandom_range(9) == 0) send_item(KIND_CHAR, uqsd_pkg::CHAR_PLUS);
      send_item(KIND_CHAR, pick_hex_char());
      if ($urandom_range(9) == 0) send_item(KIND_CHAR, uqsd_pkg::CHAR_PLUS);
      send_item(KIND_CHAR, pick_hex_char());
   endtask

   task automatic send_field_text();
      int n;
      int i;
      n = $urandom_range(5);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(4) == 0) send_escape();
         else send_item(KIND_CHAR, pick_text_byte());
      end
   endtask

   task automatic send_random_url();
      int n;
      int i;
      n = $urandom_range(6);
      for (i = 0; i < n; i++) begin
         send_item(KIND_CHAR, pick_text_byte());
      end
      if ($urandom_range(9) != 0) begin
         send_item(KIND_CHAR, uqsd_pkg::CHAR_QUERY);
         n = $urandom_range(4);
         for (i = 0; i < n; i++) begin
            if (i != 0) send_item(KIND_CHAR, uqsd_pkg::CHAR_AMP);
            send_field_text();
            if ($urandom_range(4) != 0) begin
               send_item(KIND_CHAR, uqsd_pkg::CHAR_EQUAL);
               send_field_text();
            end
         end
      end
      // now and then leave the string open so the next one runs on
      if ($urandom_range(19) != 0) send_end();
   endtask

   task automatic send_noise();
      int n;
      int i;
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) begin
         send_item(($urandom_range(7) == 0) ? KIND_END : KIND_CHAR, 8'($urandom_range(255)));
      end
   endtask

   task automatic test_directed();
      send_end();                       // end marker right after reset
      send_item(KIND_CHAR, 8'h00);
      send_item(KIND_CHAR, 8'hFF);
      send_text("%+?");                 // literal percent, space, close path
      send_text("k%+f%Az&");            // plus and restart inside a key escape
      send_text("=%4+1&");              // empty key, plus in second digit slot
      send_text("v=%a");
      send_end();                       // drop a half escape, close value
      send_text("?q");
      send_end();                       // key closes with empty value
      send_text("?%");
      send_end();                       // end during first escape digit
      drain_results();
   endtask

   task automatic test_receiver_hold();
      int i;
      hold_req <= ~hold_req;
      for (i = 0; i < 8; i++) send_random_url();
      drain_results();
   endtask

   task automatic test_sender_pause();
      int i;
      for (i = 0; i < 4; i++) begin
         send_random_url();
         drain_results();
      end
   endtask

   task automatic test_no_idle();
      int start;
      start = items_sent;
      idle_on = 1'b0;
      while (items_sent - start < 150) send_random_url();
      idle_on = 1'b1;
   endtask

   task automatic test_random_urls();
      int start;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         if ($urandom_range(9) == 0) send_noise();
         else send_random_url();
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_kind    = KIND_CHAR;
      req_char_in = 8'h00;
      rsp_stall   = 1'b0;
      reset_url_state();
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_receiver_hold();
      test_sender_pause();
      test_no_idle();
      test_random_urls();

      drain_results();
      if (mismatch_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/uqsd_pkg.sv
hdl/uqsd_step.sv
hdl/url_query_string_decoder.sv
hdl/uqsd_checker.sv
bench/tb.sv
